// File: hdl/asra_pkg.sv
// Shared types, codes and default sizes for the shelf atlas rectangle allocator.
// Used by the top level, the rectangle memory and the port checker.
package asra_pkg;

    localparam int DEF_MAX_PAGES          = 16;
    localparam int DEF_MAX_RECTS_PER_PAGE = 64;
    localparam int DEF_MAX_SIDE           = 4096;

    localparam logic [12:0] ATLAS_SIDE_RESET    = 13'd4096;
    localparam logic [12:0] RESERVED_SIDE_RESET = 13'd32;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;

    localparam logic CFG_ATLAS_SIDE    = 1'b0;
    localparam logic CFG_RESERVED_SIDE = 1'b1;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic [12:0] w;
        logic [12:0] h;
    } t_rect;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  page;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [12:0] width;
        logic [12:0] height;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_page;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [12:0] out_width;
        logic [12:0] out_height;
        logic        in_place;
        logic [4:0]  pages_in_use;
    } t_out;

endpackage

// File: hdl/asra_rect_mem.sv
// Rectangle table storage: one write port and one read port with registered data.
// Depends on asra_pkg for the rectangle entry type.
module asra_rect_mem #(
    parameter int DEPTH = asra_pkg::DEF_MAX_PAGES * asra_pkg::DEF_MAX_RECTS_PER_PAGE,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  asra_pkg::t_rect  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output asra_pkg::t_rect  o_rdata
);

    asra_pkg::t_rect r_mem [DEPTH];
    asra_pkg::t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/atlas_shelf_rect_allocator_top.sv
// Shelf atlas rectangle allocator: sequencer, page counts and result register.
// Depends on asra_pkg and asra_rect_mem.
//
// The input is not ready while a command is running. The rectangle table is a
// single-port-read memory, so every table entry visited costs an address
// step and then a registered-data step. Allocate scans the pages from last
// to first, then shifts the entries behind the new one; free looks up the
// rectangle and closes the gap; resize looks it up, widens it in place where
// it can, and else closes the gap and allocates anew. After reset the init
// state writes the reserved square before the first transfer is taken. A
// finished result waits in an output register, so the next command can be
// taken while it is still pending.
module atlas_shelf_rect_allocator_top #(
    parameter int MAX_PAGES          = asra_pkg::DEF_MAX_PAGES,
    parameter int MAX_RECTS_PER_PAGE = asra_pkg::DEF_MAX_RECTS_PER_PAGE,
    parameter int MAX_SIDE           = asra_pkg::DEF_MAX_SIDE
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  asra_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output asra_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [12:0]    i_cfg_data
);

    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int IDX_W = $clog2(MAX_RECTS_PER_PAGE);
    localparam int CNT_W = $clog2(MAX_RECTS_PER_PAGE + 1);
    localparam int PT_W  = $clog2(MAX_PAGES + 1);
    localparam int DEPTH = MAX_PAGES * MAX_RECTS_PER_PAGE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_FIND_RD  = 4'd2;
    localparam logic [3:0] S_FIND_CHK = 4'd3;
    localparam logic [3:0] S_NEXT_RD  = 4'd4;
    localparam logic [3:0] S_NEXT_CHK = 4'd5;
    localparam logic [3:0] S_REM_RD   = 4'd6;
    localparam logic [3:0] S_REM_WR   = 4'd7;
    localparam logic [3:0] S_PG       = 4'd8;
    localparam logic [3:0] S_SCAN_RD  = 4'd9;
    localparam logic [3:0] S_SCAN_CHK = 4'd10;
    localparam logic [3:0] S_ADV      = 4'd11;
    localparam logic [3:0] S_NEWPG    = 4'd12;
    localparam logic [3:0] S_INS_RD   = 4'd13;
    localparam logic [3:0] S_INS_WR   = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    function automatic logic [AW-1:0] f_addr(input logic [PG_W-1:0] p,
                                             input logic [IDX_W-1:0] i);
        int a;
        a = int'(p) * MAX_RECTS_PER_PAGE + int'(i);
        return AW'(a);
    endfunction

    logic [3:0]       r_state;
    logic [12:0]      r_atlas;
    logic [12:0]      r_resv;
    logic [CNT_W-1:0] r_cnt [MAX_PAGES];
    logic [PT_W-1:0]  r_pt;
    logic             r_ovalid;
    asra_pkg::t_out   r_odata;

    logic [1:0]       r_cmd;
    logic [3:0]       r_pg;
    logic [11:0]      r_px;
    logic [11:0]      r_py;
    logic [12:0]      r_w;
    logic [12:0]      r_h;
    logic [12:0]      r_side;
    logic [PG_W-1:0]  r_q;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_n;
    logic [IDX_W-1:0] r_idx;
    asra_pkg::t_rect  r_ent;
    logic [12:0]      r_rowy;
    logic [13:0]      r_rowx;
    logic             r_match;
    logic [13:0]      r_last_end;
    logic [CNT_W-1:0] r_ins_i;
    asra_pkg::t_rect  r_ins_rect;
    logic [1:0]       r_status;
    asra_pkg::t_rect  r_res;
    logic [3:0]       r_res_pg;
    logic             r_inplace;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    asra_pkg::t_rect  mem_wdata;
    logic [AW-1:0]    mem_raddr;
    asra_pkg::t_rect  rd;

    logic             in_xfer;
    logic             out_load;
    logic [12:0]      side_c;
    logic [12:0]      w_c;
    logic [12:0]      h_c;
    logic [12:0]      resv_c;
    logic             blank;
    logic [PG_W-1:0]  cnt_sel;
    logic [CNT_W-1:0] cnt_rd;
    logic [PG_W-1:0]  pg_i;
    logic [CNT_W-1:0] j_inc;
    logic [CNT_W-1:0] j_dec;
    logic             hit;
    logic [12:0]      lim;
    logic             ip_ok;
    logic             newrow;
    logic             endrow_fit;
    logic             end_band_fit;
    logic             band_fit;
    logic             st_match;
    logic             first_fit;
    logic             cont_fit;
    logic [PG_W-1:0]  pt_pg;

    asra_rect_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign out_load    = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_comb begin
        side_c = r_atlas;
        if (r_atlas == 13'd0) begin
            side_c = 13'd1;
        end else if (r_atlas > 13'(MAX_SIDE)) begin
            side_c = 13'(MAX_SIDE);
        end
        resv_c = (r_resv > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : r_resv;
        w_c    = (i_in_data.width > side_c) ? side_c : i_in_data.width;
        h_c    = (i_in_data.height > side_c) ? side_c : i_in_data.height;
        blank  = (i_in_data.page == 4'd0) && (i_in_data.pos_x == 12'd0)
                 && (i_in_data.pos_y == 12'd0);
    end

    assign cnt_sel = (r_state == S_IDLE) ? i_in_data.page[PG_W-1:0] : r_q;
    assign cnt_rd  = r_cnt[cnt_sel];
    assign pg_i    = r_pg[PG_W-1:0];
    assign pt_pg   = r_pt[PG_W-1:0];
    assign j_inc   = r_j + CNT_W'(1);
    assign j_dec   = r_j - CNT_W'(1);

    // In-place widening is bounded by the next rectangle of the same row.
    assign hit   = (rd.x == {1'b0, r_px}) && (rd.y == {1'b0, r_py});
    assign lim   = ((r_state == S_NEXT_CHK) && (rd.y == r_ent.y)) ? rd.x : r_side;
    assign ip_ok = (15'(r_px) + 15'(r_w)) <= 15'(lim);

    // Shelf scan decisions for the entry just read.
    assign newrow       = (r_j == '0) || (rd.y != r_rowy);
    assign endrow_fit   = r_match && (15'(r_side) >= 15'(r_rowx) + 15'(r_w));
    assign end_band_fit = 15'(r_side) >= 15'(r_last_end) + 15'(r_h);
    assign band_fit     = 15'(rd.y) >= 15'(r_last_end) + 15'(r_h);
    assign st_match     = (rd.h == r_h);
    assign first_fit    = st_match && (15'(rd.x) >= 15'(r_w));
    assign cont_fit     = r_match && (15'(rd.x) >= 15'(r_rowx) + 15'(r_w));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '{x: 13'd0, y: 13'd0,
                              w: asra_pkg::RESERVED_SIDE_RESET,
                              h: asra_pkg::RESERVED_SIDE_RESET};
            end
            S_IDLE: begin
                if (in_xfer && (i_in_data.command == asra_pkg::CMD_CLEAR)) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{x: 13'd0, y: 13'd0, w: resv_c, h: resv_c};
                end
            end
            S_FIND_RD, S_NEXT_RD: begin
                mem_raddr = f_addr(pg_i, r_j[IDX_W-1:0]);
            end
            S_FIND_CHK: begin
                mem_waddr = f_addr(pg_i, r_j[IDX_W-1:0]);
                mem_wdata = '{x: rd.x, y: rd.y, w: r_w, h: rd.h};
                mem_we    = hit && (r_cmd == asra_pkg::CMD_RESIZE) && st_match
                            && !(j_inc < r_n) && ip_ok;
            end
            S_NEXT_CHK: begin
                mem_waddr = f_addr(pg_i, r_idx);
                mem_wdata = '{x: r_ent.x, y: r_ent.y, w: r_w, h: r_ent.h};
                mem_we    = ip_ok;
            end
            S_REM_RD: begin
                mem_raddr = f_addr(pg_i, j_inc[IDX_W-1:0]);
            end
            S_REM_WR: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(pg_i, r_j[IDX_W-1:0]);
                mem_wdata = rd;
            end
            S_SCAN_RD: begin
                mem_raddr = f_addr(r_q, r_j[IDX_W-1:0]);
            end
            S_NEWPG: begin
                mem_we    = (r_pt < PT_W'(MAX_PAGES));
                mem_waddr = f_addr(pt_pg, '0);
                mem_wdata = '{x: 13'd0, y: 13'd0, w: r_w, h: r_h};
            end
            S_INS_RD: begin
                mem_raddr = f_addr(r_q, j_dec[IDX_W-1:0]);
                if (r_j == r_ins_i) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(r_q, r_ins_i[IDX_W-1:0]);
                    mem_wdata = r_ins_rect;
                end
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_q, r_j[IDX_W-1:0]);
                mem_wdata = rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_atlas  <= asra_pkg::ATLAS_SIDE_RESET;
            r_resv   <= asra_pkg::RESERVED_SIDE_RESET;
            r_pt     <= PT_W'(1);
            r_ovalid <= 1'b0;
            for (int p = 0; p < MAX_PAGES; p++) begin
                r_cnt[p] <= (p == 0) ? CNT_W'(1) : '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == asra_pkg::CFG_ATLAS_SIDE) begin
                    r_atlas <= i_cfg_data;
                end else begin
                    r_resv <= i_cfg_data;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end

                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd     <= i_in_data.command;
                        r_pg      <= i_in_data.page;
                        r_px      <= i_in_data.pos_x;
                        r_py      <= i_in_data.pos_y;
                        r_w       <= w_c;
                        r_h       <= h_c;
                        r_side    <= side_c;
                        r_status  <= asra_pkg::ST_DONE;
                        r_res     <= '0;
                        r_res_pg  <= 4'd0;
                        r_inplace <= 1'b0;
                        r_j       <= '0;
                        r_n       <= cnt_rd;
                        r_q       <= PG_W'(r_pt - PT_W'(1));
                        case (i_in_data.command)
                            asra_pkg::CMD_ALLOC: begin
                                r_state <= S_PG;
                            end
                            asra_pkg::CMD_CLEAR: begin
                                for (int p = 0; p < MAX_PAGES; p++) begin
                                    r_cnt[p] <= (p == 0) ? CNT_W'(1) : '0;
                                end
                                r_pt    <= PT_W'(1);
                                r_state <= S_DONE;
                            end
                            default: begin
                                if (blank || (6'(i_in_data.page) >= 6'(r_pt))) begin
                                    if (i_in_data.command == asra_pkg::CMD_FREE) begin
                                        r_status <= asra_pkg::ST_NOT_FOUND;
                                        r_state  <= S_DONE;
                                    end else begin
                                        r_state <= S_PG;
                                    end
                                end else begin
                                    r_state <= S_FIND_RD;
                                end
                            end
                        endcase
                    end
                end

                S_FIND_RD: begin
                    if (r_j == r_n) begin
                        if (r_cmd == asra_pkg::CMD_FREE) begin
                            r_status <= asra_pkg::ST_NOT_FOUND;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_PG;
                        end
                    end else begin
                        r_state <= S_FIND_CHK;
                    end
                end

                S_FIND_CHK: begin
                    if (hit) begin
                        r_idx <= r_j[IDX_W-1:0];
                        r_ent <= rd;
                        if ((r_cmd == asra_pkg::CMD_FREE) || !st_match) begin
                            r_state <= S_REM_RD;
                        end else if (j_inc < r_n) begin
                            r_j     <= j_inc;
                            r_state <= S_NEXT_RD;
                        end else if (ip_ok) begin
                            r_res     <= '{x: rd.x, y: rd.y, w: r_w, h: rd.h};
                            r_res_pg  <= r_pg;
                            r_inplace <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_REM_RD;
                        end
                    end else begin
                        r_j     <= j_inc;
                        r_state <= S_FIND_RD;
                    end
                end

                S_NEXT_RD: begin
                    r_state <= S_NEXT_CHK;
                end

                S_NEXT_CHK: begin
                    if (ip_ok) begin
                        r_res     <= '{x: r_ent.x, y: r_ent.y, w: r_w, h: r_ent.h};
                        r_res_pg  <= r_pg;
                        r_inplace <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_j     <= CNT_W'(r_idx);
                        r_state <= S_REM_RD;
                    end
                end

                S_REM_RD: begin
                    if (!(j_inc < r_n)) begin
                        r_cnt[pg_i] <= r_n - CNT_W'(1);
                        if (r_cmd == asra_pkg::CMD_FREE) begin
                            // The last page goes away once its last rectangle does.
                            if ((r_n == CNT_W'(1)) && (r_pt > PT_W'(1))
                                && ((6'(r_pg) + 6'd1) == 6'(r_pt))) begin
                                r_pt <= r_pt - PT_W'(1);
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_PG;
                        end
                    end else begin
                        r_state <= S_REM_WR;
                    end
                end

                S_REM_WR: begin
                    r_j     <= j_inc;
                    r_state <= S_REM_RD;
                end

                S_PG: begin
                    r_n        <= cnt_rd;
                    r_j        <= '0;
                    r_match    <= 1'b0;
                    r_last_end <= '0;
                    r_rowx     <= '0;
                    r_rowy     <= '0;
                    if (cnt_rd >= CNT_W'(MAX_RECTS_PER_PAGE)) begin
                        r_state <= S_ADV;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end

                S_SCAN_RD: begin
                    if (r_j == r_n) begin
                        // Past the last entry: finish the open row, else the space below.
                        r_ins_i <= r_n;
                        r_j     <= r_n;
                        if (endrow_fit) begin
                            r_ins_rect <= '{x: r_rowx[12:0], y: r_rowy, w: r_w, h: r_h};
                            r_state    <= S_INS_RD;
                        end else if (end_band_fit) begin
                            r_ins_rect <= '{x: 13'd0, y: r_last_end[12:0], w: r_w, h: r_h};
                            r_state    <= S_INS_RD;
                        end else begin
                            r_state <= S_ADV;
                        end
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end

                S_SCAN_CHK: begin
                    r_ins_i <= r_j;
                    if (newrow && (r_j != '0) && endrow_fit) begin
                        r_ins_rect <= '{x: r_rowx[12:0], y: r_rowy, w: r_w, h: r_h};
                        r_j        <= r_n;
                        r_state    <= S_INS_RD;
                    end else if (newrow && (r_j != '0) && band_fit) begin
                        r_ins_rect <= '{x: 13'd0, y: r_last_end[12:0], w: r_w, h: r_h};
                        r_j        <= r_n;
                        r_state    <= S_INS_RD;
                    end else if (newrow && first_fit) begin
                        r_ins_rect <= '{x: 13'd0, y: rd.y, w: r_w, h: r_h};
                        r_j        <= r_n;
                        r_state    <= S_INS_RD;
                    end else if (!newrow && cont_fit) begin
                        r_ins_rect <= '{x: r_rowx[12:0], y: r_rowy, w: r_w, h: r_h};
                        r_j        <= r_n;
                        r_state    <= S_INS_RD;
                    end else begin
                        if (newrow) begin
                            r_rowy  <= rd.y;
                            r_match <= st_match;
                        end
                        r_rowx     <= 14'(rd.x) + 14'(rd.w);
                        r_last_end <= 14'(rd.y) + 14'(rd.h);
                        r_j        <= j_inc;
                        r_state    <= S_SCAN_RD;
                    end
                end

                S_ADV: begin
                    if (r_q == '0) begin
                        r_state <= S_NEWPG;
                    end else begin
                        r_q     <= r_q - PG_W'(1);
                        r_state <= S_PG;
                    end
                end

                S_NEWPG: begin
                    if (r_pt < PT_W'(MAX_PAGES)) begin
                        r_cnt[pt_pg] <= CNT_W'(1);
                        r_res        <= '{x: 13'd0, y: 13'd0, w: r_w, h: r_h};
                        r_res_pg     <= 4'(r_pt);
                        r_pt         <= r_pt + PT_W'(1);
                    end else begin
                        r_status <= asra_pkg::ST_NO_SPACE;
                    end
                    r_state <= S_DONE;
                end

                S_INS_RD: begin
                    if (r_j == r_ins_i) begin
                        r_cnt[r_q] <= r_n + CNT_W'(1);
                        r_res      <= r_ins_rect;
                        r_res_pg   <= 4'(r_q);
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end

                S_INS_WR: begin
                    r_j     <= j_dec;
                    r_state <= S_INS_RD;
                end

                S_DONE: begin
                    if (out_load) begin
                        r_odata.status          <= r_status;
                        r_odata.out_page        <= r_res_pg;
                        r_odata.out_x           <= r_res.x[11:0];
                        r_odata.out_y           <= r_res.y[11:0];
                        r_odata.out_width       <= r_res.w;
                        r_odata.out_height      <= r_res.h;
                        r_odata.in_place        <= r_inplace;
                        r_odata.pages_in_use    <= 5'(r_pt);
                        r_state                 <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/asra_checker.sv
// Port-level checks for the shelf atlas allocator, bound to the top level.
// Depends on asra_pkg for codes and the default page limit.
module asra_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input asra_pkg::t_out o_out_data
);

    // A command leaves the idle state, so the input closes right after a transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != asra_pkg::ST_DONE)) |->
        ((o_out_data.out_width == 13'd0) && (o_out_data.out_height == 13'd0)
         && (o_out_data.out_x == 12'd0) && (o_out_data.out_y == 12'd0)
         && !o_out_data.in_place))
        else $error("failed command reports a rectangle");

    a_pages_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.pages_in_use != 5'd0)
         && (o_out_data.pages_in_use <= 5'(asra_pkg::DEF_MAX_PAGES))))
        else $error("page count out of range");

    a_inplace_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.in_place) |->
        (5'(o_out_data.out_page) < o_out_data.pages_in_use))
        else $error("in-place resize on a page that is not open");

endmodule

bind atlas_shelf_rect_allocator_top asra_checker u_asra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
